// ===== src/ssrb_pkg.sv =====
`default_nettype none
package ssrb_pkg;

  localparam int WordsPerLine = 40;
  localparam int Lines        = 400;
  localparam int FbWords      = WordsPerLine * Lines;
  localparam int FbPixels     = WordsPerLine * 16;
  localparam int AddrW        = $clog2(FbWords);
  localparam int QueueDepth   = 2;
  localparam int QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW        = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_PLOT   = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [AddrW-1:0] addr;
    logic [15:0]      word_lo;
    logic [15:0]      word_hi;
    logic             spill;
    logic             clip;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/ssrb_front.sv =====
`default_nettype none
module ssrb_front (
  input  wire logic [1:0]  operation_i,
  input  wire logic [9:0]  pos_x_i,
  input  wire logic [8:0]  pos_y_i,
  input  wire logic [8:0]  row_offset_i,
  input  wire logic [15:0] pattern_i,
  input  wire logic [13:0] word_address_i,
  input  wire logic [15:0] write_data_i,
  output ssrb_pkg::cmd_t   cmd_o
);

  logic [9:0]  line;
  logic [5:0]  col;
  logic [3:0]  shift;
  logic [31:0] shifted;
  logic        x_ok;
  logic        y_ok;
  logic        line_ok;
  logic        last_col;
  logic        addr_ok;
  logic [31:0] plot_addr;

  assign line     = 10'(pos_y_i) + 10'(row_offset_i);
  assign col      = pos_x_i[9:4];
  assign shift    = pos_x_i[3:0];
  assign shifted  = {pattern_i, 16'b0} >> shift;
  assign x_ok     = 32'(pos_x_i) < 32'(ssrb_pkg::FbPixels);
  assign y_ok     = 32'(pos_y_i) < 32'(ssrb_pkg::Lines);
  assign line_ok  = 32'(line) < 32'(ssrb_pkg::Lines);
  assign last_col = (32'(col) + 32'd1) >= 32'(ssrb_pkg::WordsPerLine);
  assign addr_ok  = 32'(word_address_i) < 32'(ssrb_pkg::FbWords);
  assign plot_addr = 32'(line) * 32'(ssrb_pkg::WordsPerLine) + 32'(col);

  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = ssrb_pkg::CMD_REPORT;
    cmd_o.word_lo = write_data_i;
    case (ssrb_pkg::op_e'(operation_i))
      ssrb_pkg::OP_PLOT: begin
        if (x_ok && y_ok && line_ok) begin
          cmd_o.kind    = ssrb_pkg::CMD_PLOT;
          cmd_o.addr    = plot_addr[ssrb_pkg::AddrW-1:0];
          cmd_o.word_lo = shifted[31:16];
          cmd_o.word_hi = shifted[15:0];
          // right spill past the last word of the line is dropped
          cmd_o.spill   = (shift != 4'd0) && !last_col;
          cmd_o.clip    = (shift != 4'd0) && last_col;
        end else begin
          cmd_o.clip = 1'b1;
        end
      end
      ssrb_pkg::OP_READ: begin
        if (addr_ok) begin
          cmd_o.kind = ssrb_pkg::CMD_READ;
          cmd_o.addr = ssrb_pkg::AddrW'(word_address_i);
        end
      end
      ssrb_pkg::OP_WRITE: begin
        if (addr_ok) begin
          cmd_o.kind = ssrb_pkg::CMD_WRITE;
          cmd_o.addr = ssrb_pkg::AddrW'(word_address_i);
        end
      end
      default: begin
        cmd_o.kind = ssrb_pkg::CMD_REPORT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ssrb_queue.sv =====
`default_nettype none
module ssrb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ssrb_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output ssrb_pkg::cmd_t      head_o,
  output logic                empty_o,
  output logic                full_o
);

  ssrb_pkg::cmd_t                  slot_q [ssrb_pkg::QueueDepth];
  logic [ssrb_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [ssrb_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [ssrb_pkg::QCntW-1:0]      count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == ssrb_pkg::QCntW'(ssrb_pkg::QueueDepth));
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ssrb_pkg::QPtrW'(ssrb_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ssrb_pkg::QPtrW'(ssrb_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/ssrb_back.sv =====
`default_nettype none
module ssrb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssrb_pkg::cmd_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               done_o,
  output logic [15:0]        read_data_o,
  output logic               clipped_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PLOT_LO,
    ST_PLOT_HI
  } state_e;

  state_e                       state_q, state_d;
  ssrb_pkg::cmd_t               cur_q, cur_d;
  logic [ssrb_pkg::AddrW-1:0]   clr_q, clr_d;
  logic                         done_q, done_d;
  logic [15:0]                  rdout_q, rdout_d;
  logic                         clip_q, clip_d;

  logic [15:0]                  mem_q [ssrb_pkg::FbWords];
  logic [15:0]                  rdata_q;
  logic                         mem_we;
  logic [ssrb_pkg::AddrW-1:0]   mem_waddr;
  logic [15:0]                  mem_wdata;
  logic [ssrb_pkg::AddrW-1:0]   mem_raddr;

  assign clearing_o  = (state_q == ST_CLEAR);
  assign done_o      = done_q;
  assign read_data_o = rdout_q;
  assign clipped_o   = clip_q;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    rdout_d   = '0;
    clip_d    = 1'b0;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_i.addr;
    mem_wdata = head_i.word_lo;
    mem_raddr = head_i.addr;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ssrb_pkg::AddrW'(ssrb_pkg::FbWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = head_i;
          case (head_i.kind)
            ssrb_pkg::CMD_READ:  state_d = ST_READ;
            ssrb_pkg::CMD_PLOT:  state_d = ST_PLOT_LO;
            ssrb_pkg::CMD_WRITE: begin
              mem_we = 1'b1;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
              clip_d = head_i.clip;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        rdout_d = rdata_q;
        state_d = ST_IDLE;
      end
      ST_PLOT_LO: begin
        // merge first word while fetching the spill word
        mem_we    = 1'b1;
        mem_waddr = cur_q.addr;
        mem_wdata = rdata_q | cur_q.word_lo;
        mem_raddr = cur_q.addr + 1'b1;
        if (cur_q.spill) begin
          state_d = ST_PLOT_HI;
        end else begin
          done_d  = 1'b1;
          clip_d  = cur_q.clip;
          state_d = ST_IDLE;
        end
      end
      ST_PLOT_HI: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q.addr + 1'b1;
        mem_wdata = rdata_q | cur_q.word_hi;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_q   <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
      rdout_q <= '0;
      clip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      rdout_q <= rdout_d;
      clip_q  <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule
`default_nettype wire

// ===== src/shifted_sprite_row_blitter_unit.sv =====
`default_nettype none
// sprite-row blitter over a 640x400 one-bit framebuffer of 16-bit words.
// a beat is taken when start is high and busy is low; every beat yields one
// result, shown for a single cycle with done_o high, and the receiver cannot
// stall it. after reset the block sweeps the framebuffer to zero, one word a
// cycle, and holds busy high until the sweep ends. beats enter a two-entry
// queue; the back end finishes a write, a rejected plot or an unused code in
// the idle state that pops it, a read in ST_READ, a plot without spill in
// ST_PLOT_LO, and a plot that spills into the next word in ST_PLOT_HI after
// ST_PLOT_LO, as the single write port of the framebuffer memory allows. the
// result appears in the cycle after the back end finishes the beat.
module shifted_sprite_row_blitter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [9:0]  pos_x_i,
  input  wire logic [8:0]  pos_y_i,
  input  wire logic [8:0]  row_offset_i,
  input  wire logic [15:0] pattern_i,
  input  wire logic [13:0] word_address_i,
  input  wire logic [15:0] write_data_i,
  output logic             done_o,
  output logic [15:0]      read_data_o,
  output logic             clipped_o
);

  ssrb_pkg::cmd_t in_cmd;
  ssrb_pkg::cmd_t head_cmd;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;
  logic           clearing;

  assign busy = q_full || clearing;

  ssrb_front u_front (
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .row_offset_i   (row_offset_i),
    .pattern_i      (pattern_i),
    .word_address_i (word_address_i),
    .write_data_i   (write_data_i),
    .cmd_o          (in_cmd)
  );

  ssrb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !busy),
    .push_cmd_i (in_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  ssrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .clearing_o  (clearing),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .clipped_o   (clipped_o)
  );

endmodule
`default_nettype wire
